### hdl/lzwe_pkg.sv
// ----------------------------------------------------------------------------
// lzwe_pkg
// Shared constants, types and helpers of the LZW byte stream encoder.
// ----------------------------------------------------------------------------
package lzwe_pkg;

    // Dictionary sizing
    localparam int CODE_BITS  = 16;
    localparam int SLOT_BITS  = CODE_BITS + 1;
    localparam int KEY_BITS   = CODE_BITS + 8;
    localparam int EPOCH_BITS = 8;
    localparam int ENTRY_BITS = EPOCH_BITS + KEY_BITS + CODE_BITS;
    localparam int SLOT_COUNT = 1 << SLOT_BITS;
    localparam int OUT_BITS   = 16;

    localparam logic [CODE_BITS:0] FIRST_FREE = (CODE_BITS + 1)'(256);
    localparam logic [31:0]        HASH_MULT  = 32'h9E37_79B1;

    // Up to two result words handed to the output queue at once
    typedef struct packed {
        logic [1:0]                cnt;
        logic [1:0][OUT_BITS-1:0]  code;
        logic [1:0]                last;
    } t_push;

    // Low output bits of a phrase code, zero-extended when codes are narrow
    function automatic logic [OUT_BITS-1:0] to_out_code(input logic [CODE_BITS-1:0] c);
        logic [31:0] w;
        w = 32'(c);
        return w[OUT_BITS-1:0];
    endfunction

endpackage

### hdl/lzwe_ram.sv
// ----------------------------------------------------------------------------
// lzwe_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lzwe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/lzwe_outq.sv
// ----------------------------------------------------------------------------
// lzwe_outq
// Two-word output queue; takes up to two result words in one cycle.
// ----------------------------------------------------------------------------
module lzwe_outq (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lzwe_pkg::t_push              i_push,
    output logic [1:0]                   o_room,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [lzwe_pkg::OUT_BITS-1:0] o_code,
    output logic                         o_last_code
);
    import lzwe_pkg::*;

    logic [1:0]                r_cnt;
    logic [1:0]                n_cnt;
    logic [1:0][OUT_BITS-1:0]  r_code;
    logic [1:0][OUT_BITS-1:0]  n_code;
    logic [1:0]                r_last;
    logic [1:0]                n_last;
    logic                      w_pop;
    logic [1:0]                w_left;

    assign w_pop  = (r_cnt != 2'd0) && !i_stall;
    assign w_left = r_cnt - {1'b0, w_pop};

    always_comb begin
        n_code = r_code;
        n_last = r_last;
        // advance head
        if (w_pop) begin
            n_code[0] = r_code[1];
            n_last[0] = r_last[1];
        end
        if (i_push.cnt != 2'd0) begin
            n_code[w_left[0]] = i_push.code[0];
            n_last[w_left[0]] = i_push.last[0];
        end
        if (i_push.cnt == 2'd2) begin
            n_code[1] = i_push.code[1];
            n_last[1] = i_push.last[1];
        end
        n_cnt = w_left + i_push.cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_code <= n_code;
        r_last <= n_last;
    end

    assign o_room      = 2'd2 - r_cnt;
    assign o_valid     = r_cnt != 2'd0;
    assign o_code      = r_code[0];
    assign o_last_code = r_last[0];

endmodule

### hdl/lzw_byte_stream_encoder.sv
// ----------------------------------------------------------------------------
// lzw_byte_stream_encoder
// LZW encoder: bytes in, phrase codes out, hashed dictionary in one RAM.
// ----------------------------------------------------------------------------
// One byte is taken at a time. A byte that opens a stream (and is not also
// its last) is only accepted; a one-byte stream goes through accept and
// result hand-off. Any other byte goes through accept and hash multiply, RAM
// address, RAM read and compare, and then a hand-off step when words go to
// the output queue; when the phrase grows and no word comes out, it skips
// the hand-off. Each extra linear probe in the dictionary adds a compare
// step, since every probe is one read of the single dictionary RAM. A result
// that finds too little room in the output queue for all its words holds the
// encoder until there is room. The dictionary is a 2^(CODE_BITS+1)-slot hash
// table tagged with an 8-bit stream epoch, so end of stream clears it at
// once; after reset, and after every 255th stream of two or more bytes when
// the epoch wraps, a clearing pass writes every slot, one a cycle, and no
// byte is taken during it. Once all 2^CODE_BITS codes are handed out the
// dictionary freezes. Codes are emitted as their low 16 bits.
// ----------------------------------------------------------------------------
module lzw_byte_stream_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_stream,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_code,
    output logic        o_last_code
);
    import lzwe_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_ADDR  = 5'b00100,
        S_CMP   = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state                 r_state, n_state;
    logic [SLOT_BITS-1:0]   r_clr_addr, n_clr_addr;
    logic [EPOCH_BITS-1:0]  r_epoch, n_epoch;
    logic [CODE_BITS-1:0]   r_phrase, n_phrase;
    logic                   r_have, n_have;
    logic [CODE_BITS:0]     r_next_free, n_next_free;
    logic [7:0]             r_byte, n_byte;
    logic                   r_eos, n_eos;
    logic [KEY_BITS-1:0]    r_key, n_key;
    logic [31:0]            r_prod, n_prod;
    logic [SLOT_BITS-1:0]   r_slot, n_slot;
    t_push                  r_push, n_push;
    logic                   r_wrap, n_wrap;

    logic                   w_wr_en;
    logic [SLOT_BITS-1:0]   w_wr_addr;
    logic [ENTRY_BITS-1:0]  w_wr_data;
    logic                   w_rd_en;
    logic [SLOT_BITS-1:0]   w_rd_addr;
    logic [ENTRY_BITS-1:0]  w_rd_data;

    logic [EPOCH_BITS-1:0]  w_e_epoch;
    logic [KEY_BITS-1:0]    w_e_key;
    logic [CODE_BITS-1:0]   w_e_code;
    logic [KEY_BITS-1:0]    w_key;
    logic [CODE_BITS-1:0]   w_new_phrase;
    logic                   w_accept;
    logic                   w_emit;
    t_push                  w_push;
    logic [1:0]             w_room;

    assign w_accept  = i_valid && !o_stall;
    assign o_stall   = r_state != S_IDLE;
    assign w_key     = {r_phrase, i_data_byte};

    assign w_e_epoch = w_rd_data[ENTRY_BITS-1 -: EPOCH_BITS];
    assign w_e_key   = w_rd_data[CODE_BITS +: KEY_BITS];
    assign w_e_code  = w_rd_data[CODE_BITS-1:0];

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_epoch     = r_epoch;
        n_phrase    = r_phrase;
        n_have      = r_have;
        n_next_free = r_next_free;
        n_byte      = r_byte;
        n_eos       = r_eos;
        n_key       = r_key;
        n_prod      = r_prod;
        n_slot      = r_slot;
        n_push      = r_push;
        n_wrap      = r_wrap;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_slot;
        w_wr_data   = {EPOCH_BITS'(r_epoch), r_key, r_next_free[CODE_BITS-1:0]};
        w_rd_en     = 1'b0;
        w_rd_addr   = r_slot;
        w_emit      = 1'b0;
        w_new_phrase = r_phrase;
        w_push      = '0;

        case (r_state)
            S_CLEAR: begin
                w_wr_en    = 1'b1;
                w_wr_addr  = r_clr_addr;
                w_wr_data  = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (&r_clr_addr) begin
                    n_epoch = EPOCH_BITS'(1);
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_byte = i_data_byte;
                    n_eos  = i_end_of_stream;
                    if (!r_have) begin
                        // open a phrase; a one-byte stream closes it at once
                        if (i_end_of_stream) begin
                            n_push.cnt  = 2'd1;
                            n_push.code = '0;
                            n_push.code[0] = to_out_code(CODE_BITS'(i_data_byte));
                            n_push.last = 2'b01;
                            n_phrase = '0;
                            n_state  = S_EMIT;
                        end else begin
                            n_phrase = CODE_BITS'(i_data_byte);
                            n_have   = 1'b1;
                        end
                    end else begin
                        n_key   = w_key;
                        n_prod  = 32'(w_key) * HASH_MULT;
                        n_state = S_ADDR;
                    end
                end
            end
            S_ADDR: begin
                n_slot    = r_prod[31 -: SLOT_BITS];
                w_rd_en   = 1'b1;
                w_rd_addr = r_prod[31 -: SLOT_BITS];
                n_state   = S_CMP;
            end
            S_CMP: begin
                if (w_e_epoch == r_epoch && w_e_key != r_key) begin
                    // occupied by another key: probe the next slot
                    n_slot    = r_slot + 1'b1;
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_slot + 1'b1;
                end else begin
                    if (w_e_epoch == r_epoch) begin
                        w_new_phrase = w_e_code;
                    end else begin
                        w_emit       = 1'b1;
                        w_new_phrase = CODE_BITS'(r_byte);
                        // store the extended phrase unless the dictionary is full
                        if (!r_next_free[CODE_BITS]) begin
                            w_wr_en     = 1'b1;
                            n_next_free = r_next_free + 1'b1;
                        end
                    end
                    n_phrase    = w_new_phrase;
                    n_push.code = '0;
                    n_push.last = 2'b00;
                    n_push.cnt  = {1'b0, w_emit};
                    n_push.code[0] = to_out_code(r_phrase);
                    if (r_eos) begin
                        if (w_emit) begin
                            n_push.code[1] = to_out_code(w_new_phrase);
                            n_push.last[1] = 1'b1;
                            n_push.cnt     = 2'd2;
                        end else begin
                            n_push.code[0] = to_out_code(w_new_phrase);
                            n_push.last[0] = 1'b1;
                            n_push.cnt     = 2'd1;
                        end
                        n_phrase    = '0;
                        n_have      = 1'b0;
                        n_next_free = FIRST_FREE;
                        n_epoch     = r_epoch + 1'b1;
                        n_wrap      = &r_epoch;
                    end
                    n_state = (r_eos || w_emit) ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT: begin
                // hold until the queue can take every word of this byte
                if (w_room >= r_push.cnt) begin
                    w_push  = r_push;
                    n_wrap  = 1'b0;
                    n_state = r_wrap ? S_CLEAR : S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_epoch     <= '0;
            r_phrase    <= '0;
            r_have      <= 1'b0;
            r_next_free <= FIRST_FREE;
            r_wrap      <= 1'b0;
            r_push.cnt  <= 2'd0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_epoch     <= n_epoch;
            r_phrase    <= n_phrase;
            r_have      <= n_have;
            r_next_free <= n_next_free;
            r_wrap      <= n_wrap;
            r_push.cnt  <= n_push.cnt;
        end
        r_byte      <= n_byte;
        r_eos       <= n_eos;
        r_key       <= n_key;
        r_prod      <= n_prod;
        r_slot      <= n_slot;
        r_push.code <= n_push.code;
        r_push.last <= n_push.last;
    end

    // A slot written in the compare step is read again no earlier than the address
    // step of the next byte, so the write has landed and no forwarding is needed.
    lzwe_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (SLOT_COUNT)
    ) u_dict (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    lzwe_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .o_room      (w_room),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_code      (o_code),
        .o_last_code (o_last_code)
    );

endmodule

### hdl/lzwe_checker.sv
// ----------------------------------------------------------------------------
// lzwe_checker
// Port-level checks of the LZW encoder, bound to its top level.
// ----------------------------------------------------------------------------
module lzwe_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [7:0]  i_data_byte,
    input logic        i_end_of_stream,
    input logic        o_valid,
    input logic        i_stall,
    input logic [15:0] o_code,
    input logic        o_last_code
);

    // reset empties the queue and starts the dictionary clearing pass
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_stall)
        else $error("encoder not quiet after reset");

    // the last byte of a stream always produces a word, so input stalls next
    a_eos_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_end_of_stream |=> o_stall)
        else $error("end of stream taken without stalling input");

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_code) && $stable(o_last_code))
        else $error("stalled output word changed");

endmodule

bind lzw_byte_stream_encoder lzwe_checker u_lzwe_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_stall         (o_stall),
    .i_data_byte     (i_data_byte),
    .i_end_of_stream (i_end_of_stream),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_code          (o_code),
    .o_last_code     (o_last_code)
);
